FILE: hdl/scoped_symbol_table_core_assert.svh
// Assertion macros shared by the symbol table RTL.
// Each macro expects a clock named clk in scope; SST_ASSERT also needs a reset named rst.
`ifndef SCOPED_SYMBOL_TABLE_CORE_ASSERT_SVH
`define SCOPED_SYMBOL_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define SST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define SST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SST_ASSERT(label, prop, msg)
`define SST_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: hdl/sst_pkg.sv
package sst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SCOPE_DEPTH = 16;
  localparam int KEY_WIDTH   = 32;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int SCOPE_W = $clog2(SCOPE_DEPTH + 1);
  localparam int SIDX_W  = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;

  // Cells are grouped; each group ends in a register stage.
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  // Fixed field widths of the channels.
  localparam int ACTION_W  = 3;
  localparam int IN_KEY_W  = 32;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int OUT_IDX_W = 7;
  localparam int OUT_CNT_W = 7;

  localparam logic [ACTION_W-1:0] ACT_OPEN   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CLOSE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SET    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SCOPE_FULL = 3'd4;

  localparam logic signed [OUT_IDX_W-1:0] NO_INDEX = -7'sd1;

  typedef logic [KEY_WIDTH-1:0]     key_t;
  typedef logic signed [DATA_W-1:0] value_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef struct packed {
    logic   wr_key;
    logic   wr_value;
    idx_t   addr;
    key_t   key;
    value_t value;
  } cell_wr_t;

  typedef struct packed {
    key_t key;
    cnt_t lo;
    cnt_t used;
  } query_t;

  typedef struct packed {
    logic   hit;
    idx_t   idx;
    value_t value;
  } match_t;

  typedef struct packed {
    logic push;
    logic pop;
    cnt_t start;
  } scope_cmd_t;

endpackage

FILE: hdl/sst_if.sv
interface sst_cmd_if import sst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [IN_KEY_W-1:0]        key;
  logic signed [DATA_W-1:0]   new_value;

  modport source(output valid, action, key, new_value, input ready);
  modport sink(input valid, action, key, new_value, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic                        found;
  logic signed [DATA_W-1:0]    read_value;
  logic signed [OUT_IDX_W-1:0] entry_index;
  logic [OUT_CNT_W-1:0]        entry_count;

  modport source(output valid, status, found, read_value, entry_index, entry_count,
                 input ready);
  modport sink(input valid, status, found, read_value, entry_index, entry_count,
               output ready);
endinterface

FILE: hdl/scoped_symbol_table_core.sv
// Channel  Dir  Payload                                                  Accepted
// cmd      in   action, key, new_value                                   valid && ready
// rsp      out  status, found, read_value, entry_index, entry_count      valid && ready
//
// Each item passes through the accept state, then a compare state in which every
// cell compares its key and the groups register their innermost hit, and then an
// update state in which the group hits are merged and the table is updated.
// The cells share a single update port, and cmd takes a new item only once idle.
// A result that is not taken stalls the update cycle; cmd is not ready meanwhile.
// Reset is synchronous and needs no clearing pass: only the state, the result valid flag,
// the entry count and the scope depth are cleared.
`include "scoped_symbol_table_core_assert.svh"

module scoped_symbol_table_core import sst_pkg::*; (
  input logic       clk,
  input logic       rst,
  sst_cmd_if.sink   cmd,
  sst_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;

  // Latched item.
  logic [ACTION_W-1:0] act;
  key_t                key_q;
  value_t              nv_q;

  // Number of live entries on the stack.
  cnt_t                used;
  cnt_t                used_next;

  // Scope stack.
  scope_cmd_t          scmd;
  logic [SCOPE_W-1:0]  scope_depth;
  cnt_t                scope_start;

  // Cells.
  query_t              query;
  cell_wr_t            wr;
  match_t              grp_match [NUM_GROUPS];
  match_t              best;

  // Result register.
  logic                        out_valid;
  logic [STATUS_W-1:0]         out_status;
  logic                        out_found;
  value_t                      out_value;
  logic signed [OUT_IDX_W-1:0] out_index;
  logic [OUT_CNT_W-1:0]        out_count;

  // Result of the action being finished.
  logic [STATUS_W-1:0]         st;
  logic                        fnd;
  value_t                      rval;
  logic signed [OUT_IDX_W-1:0] ridx;
  logic                        fire;

  assign cmd.ready = (state == S_IDLE);

  // The update cycle completes once the result register has room.
  assign fire = (state == S_SEL) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_SEL;
      end
      S_SEL: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      if (fire) begin
        used <= used_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      act   <= cmd.action;
      key_q <= key_t'(cmd.key);
      nv_q  <= cmd.new_value;
    end
  end

  // An add only looks for duplicates inside the innermost scope; lookups
  // and sets search the whole stack.
  assign query.key  = key_q;
  assign query.used = used;
  assign query.lo   = (act == ACT_ADD) ? scope_start : '0;

  sst_scope u_scope (
    .clk   (clk),
    .rst   (rst),
    .cmd   (scmd),
    .depth (scope_depth),
    .start (scope_start)
  );

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    logic [GROUP_SIZE-1:0] present;
    idx_t                  cell_idx [GROUP_SIZE];

    // The last group may hang past the end of the table; those cells never hit.
    for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_pos
      localparam int P = g * GROUP_SIZE + j;
      assign present[j]  = (P < TABLE_DEPTH);
      assign cell_idx[j] = idx_t'(P);
    end

    sst_group u_group (
      .clk      (clk),
      .present  (present),
      .cell_idx (cell_idx),
      .wr       (wr),
      .query    (query),
      .result   (grp_match[g])
    );
  end

  // Merge the registered group hits, newest group first.
  always_comb begin
    best = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (!best.hit && grp_match[g].hit) begin
        best = grp_match[g];
      end
    end
  end

  // Action decode. State changes are gated by fire at the end.
  always_comb begin
    st         = ST_OK;
    fnd        = 1'b0;
    rval       = '0;
    ridx       = NO_INDEX;
    used_next  = used;
    scmd       = '0;
    scmd.start = used;
    wr         = '0;
    wr.key     = key_q;
    wr.addr    = best.idx;
    wr.value   = nv_q;
    case (act)
      ACT_OPEN: begin
        if (scope_depth >= SCOPE_W'(SCOPE_DEPTH)) begin
          st = ST_SCOPE_FULL;
        end else begin
          scmd.push = 1'b1;
        end
      end
      ACT_CLOSE: begin
        // With no scope open the start reads as zero and the table empties.
        used_next = scope_start;
        if (scope_depth != '0) begin
          scmd.pop = 1'b1;
        end
      end
      ACT_ADD: begin
        if (best.hit) begin
          st   = ST_DUP;
          fnd  = 1'b1;
          rval = best.value;
          ridx = OUT_IDX_W'(best.idx);
        end else if (used >= CNT_W'(TABLE_DEPTH)) begin
          st = ST_TABLE_FULL;
        end else begin
          wr.wr_key   = 1'b1;
          wr.wr_value = 1'b1;
          wr.addr     = idx_t'(used);
          wr.value    = '0;
          used_next   = used + 1'b1;
          fnd         = 1'b1;
          ridx        = OUT_IDX_W'(used);
        end
      end
      ACT_LOOKUP, ACT_SET: begin
        if (best.hit) begin
          fnd  = 1'b1;
          ridx = OUT_IDX_W'(best.idx);
          if (act == ACT_SET) begin
            wr.wr_value = 1'b1;
            rval        = nv_q;
          end else begin
            rval = best.value;
          end
        end else begin
          st = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
    if (!fire) begin
      scmd.push   = 1'b0;
      scmd.pop    = 1'b0;
      wr.wr_key   = 1'b0;
      wr.wr_value = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= st;
      out_found  <= fnd;
      out_value  <= rval;
      out_index  <= ridx;
      out_count  <= OUT_CNT_W'(used_next);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found       = out_found;
  assign rsp.read_value  = out_value;
  assign rsp.entry_index = out_index;
  assign rsp.entry_count = out_count;

  `SST_ASSERT(a_used_bound, used <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `SST_ASSERT(a_miss_fields, (rsp.valid && !rsp.found) |-> (rsp.entry_index == NO_INDEX && rsp.read_value == '0), "miss result carries a match")
  `SST_ASSERT(a_full_count, (rsp.valid && rsp.status == ST_TABLE_FULL) |-> (rsp.entry_count == OUT_CNT_W'(TABLE_DEPTH)), "table full with free entries")
  `SST_ASSERT(a_stall_hold, (state == S_SEL && rsp.valid && !rsp.ready) |=> (state == S_SEL), "update ran over a waiting result")
  `SST_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !rsp.valid), "reset left work pending")

endmodule

FILE: hdl/sst_cell.sv
module sst_cell import sst_pkg::*; (
  input  logic     clk,
  input  logic     present,
  input  idx_t     idx,
  input  cell_wr_t wr,
  input  query_t   query,
  input  match_t   chain_in,
  output match_t   chain_out
);

  key_t   key;
  value_t value;
  logic   hit;

  always_ff @(posedge clk) begin
    if (wr.wr_key && wr.addr == idx) begin
      key <= wr.key;
    end
    if (wr.wr_value && wr.addr == idx) begin
      value <= wr.value;
    end
  end

  // Only live entries inside the search window take part.
  assign hit = present && (key == query.key) &&
               (cnt_t'(idx) >= query.lo) && (cnt_t'(idx) < query.used);

  // A hit from a newer cell upstream has priority over this one.
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit && hit) begin
      chain_out.hit   = 1'b1;
      chain_out.idx   = idx;
      chain_out.value = value;
    end
  end

endmodule

FILE: hdl/sst_group.sv
module sst_group import sst_pkg::*; (
  input  logic                  clk,
  input  logic [GROUP_SIZE-1:0] present,
  input  idx_t                  cell_idx [GROUP_SIZE],
  input  cell_wr_t              wr,
  input  query_t                query,
  output match_t                result
);

  match_t link [GROUP_SIZE+1];

  assign link[GROUP_SIZE] = '0;

  // The chain runs from the newest cell of the group down to the oldest.
  for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_cell
    sst_cell u_cell (
      .clk       (clk),
      .present   (present[j]),
      .idx       (cell_idx[j]),
      .wr        (wr),
      .query     (query),
      .chain_in  (link[j+1]),
      .chain_out (link[j])
    );
  end

  always_ff @(posedge clk) begin
    result <= link[0];
  end

endmodule

FILE: hdl/sst_scope.sv
module sst_scope import sst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  scope_cmd_t         cmd,
  output logic [SCOPE_W-1:0] depth,
  output cnt_t               start
);

  cnt_t               starts [SCOPE_DEPTH];
  logic [SCOPE_W-1:0] top;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.push) begin
      depth <= depth + 1'b1;
    end else if (cmd.pop) begin
      depth <= depth - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      starts[depth[SIDX_W-1:0]] <= cmd.start;
    end
  end

  assign top   = depth - 1'b1;
  assign start = (depth == '0) ? '0 : starts[top[SIDX_W-1:0]];

endmodule
